[rtl/sun_keyframe_lighting_macros.svh]
// ----------------------------------------------------------------------------
// Sun keyframe lighting assertion macros
// Implication checks sampled on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef SUN_KEYFRAME_LIGHTING_MACROS_SVH
`define SUN_KEYFRAME_LIGHTING_MACROS_SVH
`ifndef SYNTHESIS
`define SKL_ASSERT_IMP(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (cons)) \
        else $error(msg);
`define SKL_ASSERT_NXT(lbl, ant, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (cons)) \
        else $error(msg);
`else
`define SKL_ASSERT_IMP(lbl, ant, cons, msg)
`define SKL_ASSERT_NXT(lbl, ant, cons, msg)
`endif
`endif

[rtl/skl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skl_pkg
// Widths, constants and helpers shared by the sun keyframe lighting block.
// ----------------------------------------------------------------------------
package skl_pkg;

    localparam int TIME_W         = 48;
    localparam int ANG_W          = 25;
    localparam int SPD_W          = 24;
    localparam int KCNT_W         = 5;
    localparam int IDX_W          = 4;
    localparam int DIR_W          = 16;
    localparam int BRT_W          = 16;
    localparam int XY_W           = 24;
    localparam int Z_W            = 26;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 24;
    localparam int MAX_KEYS_DEF   = 16;
    localparam int COLOR_BITS_DEF = 12;

    // degrees in Q9.16
    localparam logic [ANG_W-1:0] FULL_TURN = 25'd23592960;
    localparam logic [ANG_W-1:0] DEG90     = 25'd5898240;
    localparam logic [ANG_W-1:0] DEG180    = 25'd11796480;
    localparam logic [ANG_W-1:0] DEG270    = 25'd17694720;

    localparam logic signed [XY_W-1:0] CORDIC_X0 = 24'sd636751;
    localparam logic signed [15:0]     COS30     = 16'sd14189;
    localparam logic [SPD_W-1:0]       SPEED_RST = 24'd6554;

    localparam logic [CFG_IDX_W-1:0] REG_SPEED  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_KCOUNT = 2'd1;

    typedef enum logic [1:0] {
        ACT_ADVANCE = 2'd0,
        ACT_SET     = 2'd1,
        ACT_WRITE   = 2'd2,
        ACT_NONE    = 2'd3
    } action_t;

    function automatic logic signed [Z_W-1:0] atan_q16(input logic [3:0] i);
        logic signed [Z_W-1:0] v;
        unique case (i)
            4'd0:  v = 26'sd2949120;
            4'd1:  v = 26'sd1740967;
            4'd2:  v = 26'sd919879;
            4'd3:  v = 26'sd466945;
            4'd4:  v = 26'sd234379;
            4'd5:  v = 26'sd117304;
            4'd6:  v = 26'sd58666;
            4'd7:  v = 26'sd29335;
            4'd8:  v = 26'sd14668;
            4'd9:  v = 26'sd7334;
            4'd10: v = 26'sd3667;
            4'd11: v = 26'sd1833;
            4'd12: v = 26'sd917;
            4'd13: v = 26'sd458;
            4'd14: v = 26'sd229;
            4'd15: v = 26'sd115;
            default: v = '0;
        endcase
        return v;
    endfunction

    function automatic logic signed [DIR_W-1:0] clamp_dir(input logic signed [40:0] v);
        logic signed [DIR_W-1:0] r;
        if (v > 41'sd16384)
            r = 16'sd16384;
        else if (v < -41'sd16384)
            r = -16'sd16384;
        else
            r = v[DIR_W-1:0];
        return r;
    endfunction

endpackage

[rtl/sun_keyframe_lighting_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sun keyframe lighting channels
// Item, result and register-write channels, valid/ready with payload.
// ----------------------------------------------------------------------------
interface skl_in_if #(parameter int COLOR_BITS = 12);
    import skl_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [1:0]            action;
    logic [TIME_W-1:0]     set_tick;
    logic [IDX_W-1:0]      key_index;
    logic [ANG_W-1:0]      key_angle;
    logic [COLOR_BITS-1:0] key_sky_red;
    logic [COLOR_BITS-1:0] key_sky_green;
    logic [COLOR_BITS-1:0] key_sky_blue;
    logic [COLOR_BITS-1:0] key_light_red;
    logic [COLOR_BITS-1:0] key_light_green;
    logic [COLOR_BITS-1:0] key_light_blue;
    logic [BRT_W-1:0]      key_brightness;

    modport source (
        output valid, action, set_tick, key_index, key_angle,
               key_sky_red, key_sky_green, key_sky_blue,
               key_light_red, key_light_green, key_light_blue, key_brightness,
        input  ready
    );
    modport sink (
        input  valid, action, set_tick, key_index, key_angle,
               key_sky_red, key_sky_green, key_sky_blue,
               key_light_red, key_light_green, key_light_blue, key_brightness,
        output ready
    );
endinterface

interface skl_out_if #(parameter int COLOR_BITS = 12);
    import skl_pkg::*;
    logic                    valid;
    logic                    ready;
    logic [TIME_W-1:0]       time_now;
    logic [ANG_W-1:0]        angle_now;
    logic signed [DIR_W-1:0] dir_x;
    logic signed [DIR_W-1:0] dir_y;
    logic signed [DIR_W-1:0] dir_z;
    logic [COLOR_BITS-1:0]   sky_red;
    logic [COLOR_BITS-1:0]   sky_green;
    logic [COLOR_BITS-1:0]   sky_blue;
    logic [COLOR_BITS-1:0]   light_red;
    logic [COLOR_BITS-1:0]   light_green;
    logic [COLOR_BITS-1:0]   light_blue;
    logic [BRT_W-1:0]        brightness_out;

    modport source (
        output valid, time_now, angle_now, dir_x, dir_y, dir_z,
               sky_red, sky_green, sky_blue, light_red, light_green, light_blue,
               brightness_out,
        input  ready
    );
    modport sink (
        input  valid, time_now, angle_now, dir_x, dir_y, dir_z,
               sky_red, sky_green, sky_blue, light_red, light_green, light_blue,
               brightness_out,
        output ready
    );
endinterface

interface skl_cfg_if;
    import skl_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[rtl/skl_angle.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skl_angle
// Bit-serial (tick mod 360) then bit-serial modular multiply by speed.
// ----------------------------------------------------------------------------
module skl_angle (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [skl_pkg::TIME_W-1:0] tick,
    input  logic [skl_pkg::SPD_W-1:0]  speed,
    output logic                       done,
    output logic [skl_pkg::ANG_W-1:0]  angle
);
    import skl_pkg::*;

    typedef enum logic [2:0] {
        A_IDLE = 3'b001,
        A_MOD  = 3'b010,
        A_MUL  = 3'b100
    } astate_t;

    astate_t           state_reg, state_next;
    logic [5:0]        cnt_reg, cnt_next;
    logic              done_reg, done_next;
    logic [TIME_W-1:0] sh_reg, sh_next;
    logic [SPD_W-1:0]  sp_reg, sp_next;
    logic [ANG_W-1:0]  rem_reg, rem_next;
    logic [ANG_W-1:0]  acc_reg, acc_next;
    logic [ANG_W:0]    mod_raw, mod_red, dbl_raw, dbl_red, add_raw, add_red;

    always_comb
    begin
        // remainder step: one tick bit per cycle, MSB first
        mod_raw = {rem_reg, sh_reg[TIME_W-1]};
        mod_red = (mod_raw >= {1'b0, FULL_TURN}) ? mod_raw - {1'b0, FULL_TURN} : mod_raw;
        // double-and-add, both terms kept below one turn
        dbl_raw = {acc_reg, 1'b0};
        dbl_red = (dbl_raw >= {1'b0, FULL_TURN}) ? dbl_raw - {1'b0, FULL_TURN} : dbl_raw;
        add_raw = sp_reg[SPD_W-1] ? dbl_red + {1'b0, rem_reg} : dbl_red;
        add_red = (add_raw >= {1'b0, FULL_TURN}) ? add_raw - {1'b0, FULL_TURN} : add_raw;
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        sh_next    = sh_reg;
        sp_next    = sp_reg;
        rem_next   = rem_reg;
        acc_next   = acc_reg;
        unique case (state_reg)
            A_IDLE:
            begin
                if (start)
                begin
                    sh_next    = tick;
                    rem_next   = '0;
                    cnt_next   = 6'(TIME_W - 1);
                    state_next = A_MOD;
                end
            end
            A_MOD:
            begin
                sh_next  = {sh_reg[TIME_W-2:0], 1'b0};
                rem_next = mod_red[ANG_W-1:0];
                if (cnt_reg == '0)
                begin
                    cnt_next   = 6'(SPD_W - 1);
                    acc_next   = '0;
                    sp_next    = speed;
                    state_next = A_MUL;
                end
                else
                    cnt_next = cnt_reg - 6'd1;
            end
            A_MUL:
            begin
                acc_next = add_red[ANG_W-1:0];
                sp_next  = {sp_reg[SPD_W-2:0], 1'b0};
                if (cnt_reg == '0)
                begin
                    done_next  = 1'b1;
                    state_next = A_IDLE;
                end
                else
                    cnt_next = cnt_reg - 6'd1;
            end
            default: state_next = A_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= A_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sh_reg  <= sh_next;
        sp_reg  <= sp_next;
        rem_reg <= rem_next;
        acc_reg <= acc_next;
    end

    assign done  = done_reg;
    assign angle = acc_reg;

endmodule

[rtl/skl_cordic.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skl_cordic
// Iterative 16-step rotation CORDIC, one micro-rotation per cycle, Q.20.
// ----------------------------------------------------------------------------
module skl_cordic (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             start,
    input  logic [skl_pkg::ANG_W-1:0]        angle,
    output logic                             done,
    output logic signed [skl_pkg::XY_W-1:0]  cos_q20,
    output logic signed [skl_pkg::XY_W-1:0]  sin_q20
);
    import skl_pkg::*;

    typedef enum logic [1:0] {
        C_IDLE = 2'b01,
        C_RUN  = 2'b10
    } cstate_t;

    cstate_t                state_reg, state_next;
    logic [3:0]             i_reg, i_next;
    logic                   done_reg, done_next;
    logic                   neg_reg, neg_next;
    logic signed [XY_W-1:0] x_reg, x_next, y_reg, y_next, dx, dy;
    logic signed [Z_W-1:0]  z_reg, z_next, a_ext;

    always_comb
    begin
        a_ext      = $signed({1'b0, angle});
        dx         = y_reg >>> i_reg;
        dy         = x_reg >>> i_reg;
        state_next = state_reg;
        i_next     = i_reg;
        done_next  = 1'b0;
        neg_next   = neg_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        unique case (state_reg)
            C_IDLE:
            begin
                if (start)
                begin
                    x_next   = CORDIC_X0;
                    y_next   = '0;
                    i_next   = '0;
                    neg_next = 1'b0;
                    // fold into [-90,90]; second and third quadrant flip sign
                    if (angle > DEG90 && angle < DEG270)
                    begin
                        z_next   = a_ext - $signed({1'b0, DEG180});
                        neg_next = 1'b1;
                    end
                    else if (angle >= DEG270)
                        z_next = a_ext - $signed({1'b0, FULL_TURN});
                    else
                        z_next = a_ext;
                    state_next = C_RUN;
                end
            end
            C_RUN:
            begin
                if (z_reg >= 0)
                begin
                    x_next = x_reg - dx;
                    y_next = y_reg + dy;
                    z_next = z_reg - atan_q16(i_reg);
                end
                else
                begin
                    x_next = x_reg + dx;
                    y_next = y_reg - dy;
                    z_next = z_reg + atan_q16(i_reg);
                end
                if (i_reg == 4'd15)
                begin
                    done_next  = 1'b1;
                    state_next = C_IDLE;
                end
                else
                    i_next = i_reg + 4'd1;
            end
            default: state_next = C_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            i_reg     <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            i_reg     <= i_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        neg_reg <= neg_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
        z_reg   <= z_next;
    end

    assign done    = done_reg;
    assign cos_q20 = neg_reg ? -x_reg : x_reg;
    assign sin_q20 = neg_reg ? -y_reg : y_reg;

endmodule

[rtl/skl_keys.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skl_keys
// Keyframe memory and serial scan for the pair that brackets the angle.
// ----------------------------------------------------------------------------
module skl_keys #(
    parameter int MAX_KEYS   = skl_pkg::MAX_KEYS_DEF,
    parameter int COLOR_BITS = skl_pkg::COLOR_BITS_DEF,
    localparam int AW  = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1,
    localparam int KCW = $clog2(MAX_KEYS + 1),
    localparam int CW  = 6 * COLOR_BITS + skl_pkg::BRT_W
)(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      wr_en,
    input  logic [AW-1:0]             wr_addr,
    input  logic [skl_pkg::ANG_W-1:0] wr_angle,
    input  logic [CW-1:0]             wr_col,
    input  logic                      start,
    input  logic [KCW-1:0]            count,
    input  logic [skl_pkg::ANG_W-1:0] angle,
    output logic                      done,
    output logic [skl_pkg::ANG_W-1:0] key0_ang,
    output logic [skl_pkg::ANG_W-1:0] key1_ang,
    output logic [CW-1:0]             key0_col,
    output logic [CW-1:0]             key1_col
);
    import skl_pkg::*;

    typedef enum logic [4:0] {
        K_IDLE = 5'b00001,
        K_SCAN = 5'b00010,
        K_CUR  = 5'b00100,
        K_NXT  = 5'b01000,
        K_LAST = 5'b10000
    } kstate_t;

    logic [ANG_W-1:0] ang_mem [MAX_KEYS];
    logic [CW-1:0]    col_mem [MAX_KEYS];

    kstate_t          state_reg, state_next;
    logic [KCW-1:0]   issue_reg, issue_next, pk_reg, pk_next, pk_dec, last_k;
    logic             pv_reg, pv_next, found_reg, found_next, done_reg, done_next;
    logic [AW-1:0]    cur_reg, cur_next, nxt_reg, nxt_next, rd_addr;
    logic [ANG_W-1:0] prev_reg, prev_next, ang_q_reg;
    logic [CW-1:0]    col_q_reg;
    logic [ANG_W-1:0] k0a_reg, k0a_next, k1a_reg, k1a_next;
    logic [CW-1:0]    k0c_reg, k0c_next, k1c_reg, k1c_next;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ang_mem[wr_addr] <= wr_angle;
            col_mem[wr_addr] <= wr_col;
        end
        ang_q_reg <= ang_mem[rd_addr];
        col_q_reg <= col_mem[rd_addr];
    end

    always_comb
    begin
        pk_dec = pk_reg - KCW'(1);
        last_k = count - KCW'(1);
        unique case (state_reg)
            K_CUR:   rd_addr = cur_reg;
            K_NXT:   rd_addr = nxt_reg;
            default: rd_addr = issue_reg[AW-1:0];
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        issue_next = issue_reg;
        pv_next    = 1'b0;
        pk_next    = pk_reg;
        found_next = found_reg;
        done_next  = 1'b0;
        cur_next   = cur_reg;
        nxt_next   = nxt_reg;
        prev_next  = prev_reg;
        k0a_next   = k0a_reg;
        k1a_next   = k1a_reg;
        k0c_next   = k0c_reg;
        k1c_next   = k1c_reg;
        unique case (state_reg)
            K_IDLE:
            begin
                if (start)
                begin
                    issue_next = '0;
                    found_next = 1'b0;
                    // no bracketing pair: last and first keyframes
                    cur_next   = last_k[AW-1:0];
                    nxt_next   = '0;
                    state_next = K_SCAN;
                end
            end
            K_SCAN:
            begin
                if (issue_reg != count)
                begin
                    issue_next = issue_reg + KCW'(1);
                    pv_next    = 1'b1;
                    pk_next    = issue_reg;
                end
                if (pv_reg)
                begin
                    prev_next = ang_q_reg;
                    if (pk_reg != '0 && !found_reg && prev_reg <= angle && angle < ang_q_reg)
                    begin
                        found_next = 1'b1;
                        cur_next   = pk_dec[AW-1:0];
                        nxt_next   = pk_reg[AW-1:0];
                    end
                    if (pk_reg == last_k)
                    begin
                        pv_next    = 1'b0;
                        state_next = K_CUR;
                    end
                end
            end
            K_CUR: state_next = K_NXT;
            K_NXT:
            begin
                k0a_next   = ang_q_reg;
                k0c_next   = col_q_reg;
                state_next = K_LAST;
            end
            K_LAST:
            begin
                k1a_next   = ang_q_reg;
                k1c_next   = col_q_reg;
                done_next  = 1'b1;
                state_next = K_IDLE;
            end
            default: state_next = K_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= K_IDLE;
            issue_reg <= '0;
            pv_reg    <= 1'b0;
            pk_reg    <= '0;
            found_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            issue_reg <= issue_next;
            pv_reg    <= pv_next;
            pk_reg    <= pk_next;
            found_reg <= found_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg  <= cur_next;
        nxt_reg  <= nxt_next;
        prev_reg <= prev_next;
        k0a_reg  <= k0a_next;
        k1a_reg  <= k1a_next;
        k0c_reg  <= k0c_next;
        k1c_reg  <= k1c_next;
    end

    assign done     = done_reg;
    assign key0_ang = k0a_reg;
    assign key1_ang = k1a_reg;
    assign key0_col = k0c_reg;
    assign key1_col = k1c_reg;

endmodule

[rtl/skl_blend.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skl_blend
// Restoring divide for the blend factor, then one channel per cycle mix.
// ----------------------------------------------------------------------------
module skl_blend #(
    parameter int COLOR_BITS = skl_pkg::COLOR_BITS_DEF,
    localparam int CW = 6 * COLOR_BITS + skl_pkg::BRT_W
)(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [skl_pkg::ANG_W-1:0] angle,
    input  logic [skl_pkg::ANG_W-1:0] key0_ang,
    input  logic [skl_pkg::ANG_W-1:0] key1_ang,
    input  logic [CW-1:0]             key0_col,
    input  logic [CW-1:0]             key1_col,
    output logic                      done,
    output logic [CW-1:0]             held
);
    import skl_pkg::*;

    typedef enum logic [2:0] {
        B_IDLE = 3'b001,
        B_DIV  = 3'b010,
        B_MIX  = 3'b100
    } bstate_t;

    bstate_t              state_reg, state_next;
    logic [3:0]           cnt_reg, cnt_next;
    logic [2:0]           ch_reg, ch_next;
    logic                 done_reg, done_next;
    logic [ANG_W:0]       span_reg, span_next, rem_reg, rem_next;
    logic [ANG_W:0]       na_w, sa_w, span_w, dist_w;
    logic [ANG_W+1:0]     rem2, sub_w;
    logic [15:0]          q_reg, q_next, q_shift;
    logic [16:0]          t_reg, t_next;
    logic [15:0]          c0, c1;
    logic signed [16:0]   diff;
    logic signed [34:0]   prod, adj, res_w;
    logic [COLOR_BITS-1:0] hcol_reg [6];
    logic [BRT_W-1:0]     hbrt_reg;

    always_comb
    begin
        na_w   = (key1_ang < key0_ang) ? {1'b0, key1_ang} + {1'b0, FULL_TURN}
                                       : {1'b0, key1_ang};
        sa_w   = (angle < key0_ang) ? {1'b0, angle} + {1'b0, FULL_TURN} : {1'b0, angle};
        span_w = na_w - {1'b0, key0_ang};
        dist_w = sa_w - {1'b0, key0_ang};
        rem2   = {rem_reg, 1'b0};
        sub_w  = rem2 - {1'b0, span_reg};
        if (rem2 >= {1'b0, span_reg})
            q_shift = {q_reg[14:0], 1'b1};
        else
            q_shift = {q_reg[14:0], 1'b0};
        if (ch_reg == 3'd6)
        begin
            c0 = key0_col[6*COLOR_BITS +: BRT_W];
            c1 = key1_col[6*COLOR_BITS +: BRT_W];
        end
        else
        begin
            c0 = 16'(key0_col[ch_reg*COLOR_BITS +: COLOR_BITS]);
            c1 = 16'(key1_col[ch_reg*COLOR_BITS +: COLOR_BITS]);
        end
        diff  = $signed({1'b0, c1}) - $signed({1'b0, c0});
        prod  = diff * $signed({1'b0, t_reg});
        adj   = (prod + 35'sd32768) >>> 16;
        res_w = $signed({19'd0, c0}) + adj;
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        ch_next    = ch_reg;
        done_next  = 1'b0;
        span_next  = span_reg;
        rem_next   = rem_reg;
        q_next     = q_reg;
        t_next     = t_reg;
        unique case (state_reg)
            B_IDLE:
            begin
                if (start)
                begin
                    span_next = span_w;
                    rem_next  = dist_w;
                    q_next    = '0;
                    cnt_next  = 4'd15;
                    ch_next   = '0;
                    // zero span or zero distance gives t = 0; t clamps at one
                    if (span_w == '0 || dist_w == '0)
                    begin
                        t_next     = '0;
                        state_next = B_MIX;
                    end
                    else if (dist_w >= span_w)
                    begin
                        t_next     = 17'h10000;
                        state_next = B_MIX;
                    end
                    else
                        state_next = B_DIV;
                end
            end
            B_DIV:
            begin
                q_next = q_shift;
                if (q_shift[0])
                    rem_next = sub_w[ANG_W:0];
                else
                    rem_next = rem2[ANG_W:0];
                if (cnt_reg == '0)
                begin
                    t_next     = {1'b0, q_shift};
                    state_next = B_MIX;
                end
                else
                    cnt_next = cnt_reg - 4'd1;
            end
            B_MIX:
            begin
                if (ch_reg == 3'd6)
                begin
                    done_next  = 1'b1;
                    state_next = B_IDLE;
                end
                else
                    ch_next = ch_reg + 3'd1;
            end
            default: state_next = B_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            cnt_reg   <= '0;
            ch_reg    <= '0;
            done_reg  <= 1'b0;
            hbrt_reg  <= '0;
            for (int k = 0; k < 6; k++)
                hcol_reg[k] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            ch_reg    <= ch_next;
            done_reg  <= done_next;
            if (state_reg == B_MIX)
            begin
                if (ch_reg == 3'd6)
                    hbrt_reg <= res_w[BRT_W-1:0];
                else
                    hcol_reg[ch_reg] <= res_w[COLOR_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        span_reg <= span_next;
        rem_reg  <= rem_next;
        q_reg    <= q_next;
        t_reg    <= t_next;
    end

    always_comb
    begin
        for (int k = 0; k < 6; k++)
            held[k*COLOR_BITS +: COLOR_BITS] = hcol_reg[k];
        held[6*COLOR_BITS +: BRT_W] = hbrt_reg;
    end

    assign done = done_reg;

endmodule

[rtl/sun_keyframe_lighting.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sun_keyframe_lighting
// Tick-driven sun angle, direction and keyframe-blended sky and light color.
// ----------------------------------------------------------------------------
//  channel  dir  word
//  req      in   action, set_tick, keyframe slot and values
//  rsp      out  time, sun angle, direction, blended colors, brightness
//  cfg      in   register index, write data (speed, key count)
//
//  Time update: the serial mod/multiply for the angle, then the key scan, a
//  16-step divide (none when the blend factor needs no divide) and the blend
//  of seven channels, overlapped with the 16-step CORDIC. An empty table
//  skips the scan and the blend.
//  One item in flight; the result register frees the input side while rsp stalls.
//  No clearing pass after reset; the keyframe memory is undefined until written.
`include "sun_keyframe_lighting_macros.svh"

module sun_keyframe_lighting #(
    parameter int MAX_KEYS   = skl_pkg::MAX_KEYS_DEF,
    parameter int COLOR_BITS = skl_pkg::COLOR_BITS_DEF
)(
    input logic        clk,
    input logic        rst_n,
    skl_cfg_if.sink    cfg,
    skl_in_if.sink     req,
    skl_out_if.source  rsp
);
    import skl_pkg::*;

    localparam int AW  = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
    localparam int KCW = $clog2(MAX_KEYS + 1);
    localparam int CW  = 6 * COLOR_BITS + BRT_W;

    typedef enum logic [4:0] {
        T_IDLE  = 5'b00001,
        T_ANGLE = 5'b00010,
        T_WORK  = 5'b00100,
        T_DIR   = 5'b01000,
        T_DONE  = 5'b10000
    } tstate_t;

    tstate_t                 state_reg, state_next;
    logic [TIME_W-1:0]       tick_reg, tick_next;
    logic [SPD_W-1:0]        speed_reg;
    logic [KCNT_W-1:0]       kcount_reg;
    logic                    cdone_reg, cdone_next, bdone_reg, bdone_next;
    logic signed [39:0]      prod_reg, prod_next;
    logic                    ovalid_reg, ovalid_next, load_out;
    logic [TIME_W-1:0]       otime_reg;
    logic [ANG_W-1:0]        oang_reg;
    logic signed [DIR_W-1:0] ox_reg, oy_reg, oz_reg;
    logic [CW-1:0]           ocol_reg;

    logic                    accept, time_item, wr_en;
    logic [KCW-1:0]          n_keys;
    logic [CW-1:0]           wr_col, key0_col, key1_col, held;
    logic [ANG_W-1:0]        angle, key0_ang, key1_ang;
    logic                    ang_start, ang_done, cord_start, cord_done;
    logic                    keys_start, keys_done, blend_done;
    logic signed [XY_W-1:0]  c20, s20;
    logic signed [40:0]      dx_w, dy_w, dz_w;

    assign cfg.ready = 1'b1;
    assign req.ready = (state_reg == T_IDLE);
    assign accept    = req.valid && req.ready;
    assign time_item = (action_t'(req.action) == ACT_ADVANCE) ||
                       (action_t'(req.action) == ACT_SET);
    assign wr_en     = accept && (action_t'(req.action) == ACT_WRITE) &&
                       (int'(req.key_index) < MAX_KEYS);
    assign wr_col    = {req.key_brightness, req.key_light_blue, req.key_light_green,
                        req.key_light_red, req.key_sky_blue, req.key_sky_green,
                        req.key_sky_red};
    assign n_keys    = (int'(kcount_reg) > MAX_KEYS) ? KCW'(MAX_KEYS) : KCW'(kcount_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_reg  <= SPEED_RST;
            kcount_reg <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                REG_SPEED:  speed_reg  <= cfg.data[SPD_W-1:0];
                REG_KCOUNT: kcount_reg <= cfg.data[KCNT_W-1:0];
                default: ;
            endcase
        end
    end

    skl_angle u_angle (
        .clk   (clk),
        .rst_n (rst_n),
        .start (ang_start),
        .tick  (tick_next),
        .speed (speed_reg),
        .done  (ang_done),
        .angle (angle)
    );

    skl_cordic u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cord_start),
        .angle   (angle),
        .done    (cord_done),
        .cos_q20 (c20),
        .sin_q20 (s20)
    );

    skl_keys #(
        .MAX_KEYS   (MAX_KEYS),
        .COLOR_BITS (COLOR_BITS)
    ) u_keys (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_addr  (AW'(req.key_index)),
        .wr_angle (req.key_angle),
        .wr_col   (wr_col),
        .start    (keys_start),
        .count    (n_keys),
        .angle    (angle),
        .done     (keys_done),
        .key0_ang (key0_ang),
        .key1_ang (key1_ang),
        .key0_col (key0_col),
        .key1_col (key1_col)
    );

    skl_blend #(
        .COLOR_BITS (COLOR_BITS)
    ) u_blend (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (keys_done),
        .angle    (angle),
        .key0_ang (key0_ang),
        .key1_ang (key1_ang),
        .key0_col (key0_col),
        .key1_col (key1_col),
        .done     (blend_done),
        .held     (held)
    );

    always_comb
    begin
        dx_w = (41'(prod_reg) + 41'sd524288) >>> 20;
        dy_w = (41'(s20) + 41'sd32) >>> 6;
        dz_w = (41'sd64 - 41'(c20)) >>> 7;
    end

    always_comb
    begin
        state_next  = state_reg;
        tick_next   = tick_reg;
        cdone_next  = cdone_reg;
        bdone_next  = bdone_reg;
        prod_next   = prod_reg;
        ang_start   = 1'b0;
        cord_start  = 1'b0;
        keys_start  = 1'b0;
        load_out    = 1'b0;
        ovalid_next = ovalid_reg && !rsp.ready;
        unique case (state_reg)
            T_IDLE:
            begin
                if (accept && time_item)
                begin
                    if (action_t'(req.action) == ACT_SET)
                        tick_next = req.set_tick;
                    else
                        tick_next = tick_reg + TIME_W'(1);
                    ang_start  = 1'b1;
                    state_next = T_ANGLE;
                end
            end
            T_ANGLE:
            begin
                if (ang_done)
                begin
                    cord_start = 1'b1;
                    keys_start = (n_keys != '0);
                    cdone_next = 1'b0;
                    // empty table keeps the held colors
                    bdone_next = (n_keys == '0);
                    state_next = T_WORK;
                end
            end
            T_WORK:
            begin
                cdone_next = cdone_reg || cord_done;
                bdone_next = bdone_reg || blend_done;
                if (cdone_next && bdone_next)
                    state_next = T_DIR;
            end
            T_DIR:
            begin
                prod_next  = c20 * COS30;
                state_next = T_DONE;
            end
            T_DONE:
            begin
                if (!ovalid_reg || rsp.ready)
                begin
                    load_out    = 1'b1;
                    ovalid_next = 1'b1;
                    state_next  = T_IDLE;
                end
            end
            default: state_next = T_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= T_IDLE;
            tick_reg   <= '0;
            cdone_reg  <= 1'b0;
            bdone_reg  <= 1'b0;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            tick_reg   <= tick_next;
            cdone_reg  <= cdone_next;
            bdone_reg  <= bdone_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (load_out)
        begin
            otime_reg <= tick_reg;
            oang_reg  <= angle;
            ox_reg    <= clamp_dir(dx_w);
            oy_reg    <= clamp_dir(dy_w);
            oz_reg    <= clamp_dir(dz_w);
            ocol_reg  <= held;
        end
    end

    assign rsp.valid          = ovalid_reg;
    assign rsp.time_now       = otime_reg;
    assign rsp.angle_now      = oang_reg;
    assign rsp.dir_x          = ox_reg;
    assign rsp.dir_y          = oy_reg;
    assign rsp.dir_z          = oz_reg;
    assign rsp.sky_red        = ocol_reg[0*COLOR_BITS +: COLOR_BITS];
    assign rsp.sky_green      = ocol_reg[1*COLOR_BITS +: COLOR_BITS];
    assign rsp.sky_blue       = ocol_reg[2*COLOR_BITS +: COLOR_BITS];
    assign rsp.light_red      = ocol_reg[3*COLOR_BITS +: COLOR_BITS];
    assign rsp.light_green    = ocol_reg[4*COLOR_BITS +: COLOR_BITS];
    assign rsp.light_blue     = ocol_reg[5*COLOR_BITS +: COLOR_BITS];
    assign rsp.brightness_out = ocol_reg[6*COLOR_BITS +: BRT_W];

    `SKL_ASSERT_IMP(a_angle_range, rsp.valid, rsp.angle_now < FULL_TURN, "sun angle not below a full turn")
    `SKL_ASSERT_IMP(a_dir_y_range, rsp.valid, (rsp.dir_y <= 16'sd16384) && (rsp.dir_y >= -16'sd16384), "dir_y out of unit range")
    `SKL_ASSERT_IMP(a_angle_seq, ang_done, state_reg == T_ANGLE, "angle unit finished outside its phase")
    `SKL_ASSERT_NXT(a_time_start, accept && time_item, state_reg == T_ANGLE, "time word did not start the angle unit")

endmodule

[verif/tb_sun_keyframe_lighting.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sun_keyframe_lighting
// Drives time updates and keyframe writes through the sun lighting block.
// Every result is checked against a local model of the angle, the CORDIC
// direction and the keyframe blend. Speed and key count change between phases.
// ----------------------------------------------------------------------------
module tb_sun_keyframe_lighting;
    import skl_pkg::*;

    localparam longint TURN    = 23592960;
    localparam longint Q90     = 5898240;
    localparam longint Q180    = 11796480;
    localparam longint Q270    = 17694720;
    localparam int     WD_MAX  = 5000;
    localparam int     SETTLE  = 200;

    typedef struct {
        action_t     act;
        logic [47:0] set_tick;
        logic [3:0]  idx;
        logic [24:0] angle;
        logic [11:0] sky [3];
        logic [11:0] light [3];
        logic [15:0] bright;
    } item_t;

    typedef struct {
        logic [47:0]        time_now;
        logic [24:0]        angle_now;
        logic signed [15:0] dir [3];
        logic [11:0]        sky [3];
        logic [11:0]        light [3];
        logic [15:0]        bright;
    } light_t;

    logic clk = 1'b0;
    logic rst_n;

    skl_cfg_if     cfg_if ();
    skl_in_if #(12)  req_if ();
    skl_out_if #(12) rsp_if ();

    sun_keyframe_lighting dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_if),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // local copy of block state
    logic [47:0] tick;
    logic [23:0] speed;
    logic [4:0]  nkeys;
    logic [24:0] tab_angle [16];
    logic [11:0] tab_sky [16][3];
    logic [11:0] tab_light [16][3];
    logic [15:0] tab_bright [16];
    logic [11:0] hold_sky [3];
    logic [11:0] hold_light [3];
    logic [15:0] hold_bright;

    longint atan_tab [16] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                              29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115};

    item_t  pending [$];
    light_t lighting_q [$];
    item_t  cur_item;

    int tx_idle_pct = 12;
    int rx_idle_pct = 72;
    int errors      = 0;
    int n_items     = 0;
    int n_results   = 0;
    int n_writes    = 0;
    int idle_cycles = 0;
    int stall_left  = 0;
    bit stall_done  = 1'b0;

    function automatic longint clamp_q14(input longint v);
        if (v > 16384)
            return 16384;
        if (v < -16384)
            return -16384;
        return v;
    endfunction

    function automatic longint mix(input longint c0, input longint c1, input longint t);
        return c0 + (((c1 - c0) * t + 32768) >>> 16);
    endfunction

    // apply one accepted word to the local state, queue the expected lighting
    function automatic void update_sky(input item_t it);
        longint a, x, y, z, dx, dy, ca, na, sa, span, gap, t;
        int     n, cur, nxt, k1;
        bit     neg;
        light_t r;
        if (it.act == ACT_WRITE)
        begin
            tab_angle[it.idx]  = it.angle;
            tab_sky[it.idx]    = it.sky;
            tab_light[it.idx]  = it.light;
            tab_bright[it.idx] = it.bright;
            return;
        end
        if (it.act == ACT_NONE)
            return;
        tick = (it.act == ACT_ADVANCE) ? tick + 48'd1 : it.set_tick;
        a = ((longint'(tick) % TURN) * longint'(speed)) % TURN;

        x = 636751;
        y = 0;
        z = a;
        neg = 1'b0;
        if (z > Q90 && z < Q270)
        begin
            z = z - Q180;
            neg = 1'b1;
        end
        else if (z >= Q270)
            z = z - TURN;
        for (int i = 0; i < 16; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx; y = y + dy; z = z - atan_tab[i];
            end
            else
            begin
                x = x + dx; y = y - dy; z = z + atan_tab[i];
            end
        end
        if (neg)
        begin
            x = -x;
            y = -y;
        end

        n = (nkeys > 16) ? 16 : nkeys;
        if (n > 0)
        begin
            cur = n - 1;
            nxt = 0;
            for (int k = 0; k < n; k++)
            begin
                k1 = (k + 1) % n;
                if (tab_angle[k] <= a && a < tab_angle[k1])
                begin
                    cur = k;
                    nxt = k1;
                    break;
                end
            end
            ca = tab_angle[cur];
            na = tab_angle[nxt];
            sa = a;
            if (na < ca)
                na = na + TURN;
            if (sa < ca)
                sa = sa + TURN;
            span = na - ca;
            gap  = sa - ca;
            if (span <= 0 || gap <= 0)
                t = 0;
            else
            begin
                t = (gap * 65536) / span;
                if (t > 65536)
                    t = 65536;
            end
            for (int j = 0; j < 3; j++)
            begin
                hold_sky[j]   = 12'(mix(tab_sky[cur][j], tab_sky[nxt][j], t));
                hold_light[j] = 12'(mix(tab_light[cur][j], tab_light[nxt][j], t));
            end
            hold_bright = 16'(mix(tab_bright[cur], tab_bright[nxt], t));
        end

        r.time_now  = tick;
        r.angle_now = 25'(a);
        r.dir[0]    = 16'(clamp_q14((x * 14189 + (64'sd1 <<< 19)) >>> 20));
        r.dir[1]    = 16'(clamp_q14((y + 32) >>> 6));
        r.dir[2]    = 16'(clamp_q14((64 - x) >>> 7));
        r.sky       = hold_sky;
        r.light     = hold_light;
        r.bright    = hold_bright;
        lighting_q.push_back(r);
    endfunction

    function automatic item_t make_write(input int slot, input longint ang);
        item_t it;
        it.act      = ACT_WRITE;
        it.set_tick = 48'({$urandom, $urandom});
        it.idx      = 4'(slot);
        it.angle    = 25'(ang);
        for (int j = 0; j < 3; j++)
        begin
            it.sky[j]   = 12'($urandom);
            it.light[j] = 12'($urandom);
        end
        it.bright = 16'($urandom);
        return it;
    endfunction

    function automatic item_t make_time(input action_t act, input logic [47:0] tv);
        item_t it;
        it = make_write($urandom_range(0, 15), $urandom_range(0, TURN - 1));
        it.act      = act;
        it.set_tick = tv;
        return it;
    endfunction

    function automatic item_t random_word();
        int     p;
        longint base;
        p = $urandom_range(0, 99);
        if (p < 40)
            return make_time(ACT_ADVANCE, 48'(0));
        if (p < 55)
            return make_time(ACT_SET, 48'({$urandom, $urandom}));
        if (p < 70)
            return make_time(ACT_SET, 48'($urandom_range(0, 5000)));
        if (p < 75)
            return make_time(ACT_SET, 48'hFFFF_FFFF_FFFF - 48'($urandom_range(0, 3)));
        if (p < 85)
        begin
            // keeps the table roughly sorted
            base = $urandom_range(0, 15);
            return make_write(base, base * 1474560 + $urandom_range(0, 1474559));
        end
        if (p < 95)
            return make_write($urandom_range(0, 15), $urandom_range(0, TURN - 1));
        return make_time(ACT_NONE, 48'({$urandom, $urandom}));
    endfunction

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        bit busy;
        if (!rst_n)
        begin
            req_if.valid           <= 1'b0;
            req_if.action          <= '0;
            req_if.set_tick        <= '0;
            req_if.key_index       <= '0;
            req_if.key_angle       <= '0;
            req_if.key_sky_red     <= '0;
            req_if.key_sky_green   <= '0;
            req_if.key_sky_blue    <= '0;
            req_if.key_light_red   <= '0;
            req_if.key_light_green <= '0;
            req_if.key_light_blue  <= '0;
            req_if.key_brightness  <= '0;
        end
        else
        begin
            busy = req_if.valid;
            if (req_if.valid && req_if.ready)
            begin
                update_sky(cur_item);
                n_items++;
                busy = 1'b0;
            end
            if (!busy)
            begin
                if (pending.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct)
                begin
                    cur_item = pending.pop_front();
                    req_if.valid           <= 1'b1;
                    req_if.action          <= cur_item.act;
                    req_if.set_tick        <= cur_item.set_tick;
                    req_if.key_index       <= cur_item.idx;
                    req_if.key_angle       <= cur_item.angle;
                    req_if.key_sky_red     <= cur_item.sky[0];
                    req_if.key_sky_green   <= cur_item.sky[1];
                    req_if.key_sky_blue    <= cur_item.sky[2];
                    req_if.key_light_red   <= cur_item.light[0];
                    req_if.key_light_green <= cur_item.light[1];
                    req_if.key_light_blue  <= cur_item.light[2];
                    req_if.key_brightness  <= cur_item.bright;
                end
                else
                    req_if.valid <= 1'b0;
            end
        end
    end

    function automatic void check_field(input string nm, input longint e, input longint a);
        if (e != a)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, nm, e, a);
        end
    endfunction

    // result monitor
    always @(posedge clk or negedge rst_n)
    begin
        light_t e;
        if (!rst_n)
            rsp_if.ready <= 1'b0;
        else
        begin
            if (rsp_if.valid && rsp_if.ready)
            begin
                if (lighting_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected word, expected none, got time %0d", $time,
                             rsp_if.time_now);
                end
                else
                begin
                    e = lighting_q.pop_front();
                    n_results++;
                    check_field("time_now", e.time_now, rsp_if.time_now);
                    check_field("angle_now", e.angle_now, rsp_if.angle_now);
                    check_field("dir_x", e.dir[0], rsp_if.dir_x);
                    check_field("dir_y", e.dir[1], rsp_if.dir_y);
                    check_field("dir_z", e.dir[2], rsp_if.dir_z);
                    check_field("sky_red", e.sky[0], rsp_if.sky_red);
                    check_field("sky_green", e.sky[1], rsp_if.sky_green);
                    check_field("sky_blue", e.sky[2], rsp_if.sky_blue);
                    check_field("light_red", e.light[0], rsp_if.light_red);
                    check_field("light_green", e.light[1], rsp_if.light_green);
                    check_field("light_blue", e.light[2], rsp_if.light_blue);
                    check_field("brightness_out", e.bright, rsp_if.brightness_out);
                end
            end
            rsp_if.ready <= (stall_left == 0) && ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // one long output stall so the block backs up onto its input
    always @(posedge clk)
    begin
        if (stall_left > 0)
            stall_left <= stall_left - 1;
        else if (!stall_done && n_items >= 60)
        begin
            stall_left <= 500;
            stall_done <= 1'b1;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
            (cfg_if.valid && cfg_if.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WD_MAX)
        begin
            $display("%0t: no progress for %0d cycles", $time, WD_MAX);
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [23:0] val);
        @(posedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= val;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        if (idx == REG_SPEED)
            speed = val;
        else
            nkeys = val[4:0];
        n_writes++;
        cfg_if.valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending.size() > 0 || lighting_q.size() > 0 || req_if.valid)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic run_phase(input logic [23:0] spd, input logic [4:0] keys,
                             input int tx_pct, input int rx_pct, input int count);
        drain();
        write_reg(REG_SPEED, spd);
        write_reg(REG_KCOUNT, 24'(keys));
        tx_idle_pct = tx_pct;
        rx_idle_pct = rx_pct;
        for (int i = 0; i < count; i++)
            pending.push_back(random_word());
    endtask

    initial
    begin
        longint ang;
        tick        = '0;
        speed       = SPEED_RST;
        nkeys       = '0;
        hold_sky    = '{default: '0};
        hold_light  = '{default: '0};
        hold_bright = '0;
        cfg_if.valid = 1'b0;
        cfg_if.index = REG_SPEED;
        cfg_if.data  = '0;
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty table, unused action, fill every slot, time extremes
        pending.push_back(make_time(ACT_ADVANCE, 48'(0)));
        pending.push_back(make_time(ACT_NONE, 48'(0)));
        for (int s = 0; s < 16; s++)
        begin
            ang = (s == 15) ? TURN - 1 : (s < 2 ? 0 : s * 1474560);
            pending.push_back(make_write(s, ang));
        end
        pending[2].sky   = '{12'hFFF, 12'h000, 12'hFFF};
        pending[3].light = '{12'h000, 12'hFFF, 12'h000};
        pending[17].bright = 16'hFFFF;
        pending.push_back(make_time(ACT_SET, 48'(0)));
        pending.push_back(make_time(ACT_SET, 48'hFFFF_FFFF_FFFF));
        pending.push_back(make_time(ACT_ADVANCE, 48'(0)));
        pending.push_back(make_time(ACT_SET, 48'(TURN)));
        pending.push_back(make_time(ACT_SET, 48'(TURN - 1)));

        // a pause until everything is back, then the full table at default speed
        run_phase(SPEED_RST, 5'd16, 12, 72, 150);
        pending.push_back(make_time(ACT_SET, 48'(0)));
        pending.push_back(make_time(ACT_SET, 48'd899));
        run_phase(24'd0, 5'd1, 12, 72, 140);
        run_phase(24'hFF_FFFF, 5'd31, 72, 12, 150);
        run_phase(24'($urandom), 5'd2, 72, 12, 150);
        run_phase(24'($urandom_range(1, 1 << 20)), 5'($urandom_range(0, 31)), 0, 0, 150);
        run_phase(24'd983040, 5'd16, 0, 0, 140);
        drain();

        $display("Checked %0d lighting words from %0d request words, %0d register writes.",
                 n_results, n_items, n_writes);
        $display("Covered empty, single, full and oversized key tables, speeds 0 to max.");
        if (errors == 0 && lighting_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
